[rtl/core/cmuxfd_pkg.sv]
// Shared types and constants for the multiplexer frame delineator.
package cmuxfd_pkg;

  // Register file layout
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASIC_FLAG    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ADVANCED_FLAG = 2'd2;

  localparam int unsigned ByteW = 8;

  // Reset values of the registers
  localparam logic             FRAME_MODE_RST    = 1'b0;
  localparam logic [ByteW-1:0] BASIC_FLAG_RST    = 8'hF9;
  localparam logic [ByteW-1:0] ADVANCED_FLAG_RST = 8'h7E;

  // Frame modes
  localparam logic MODE_BASIC    = 1'b0;
  localparam logic MODE_ADVANCED = 1'b1;

  // Length field widths
  localparam int unsigned LenLowW = 7;
  localparam int unsigned LenW    = 16;

  typedef struct packed {
    logic             frame_mode;
    logic [ByteW-1:0] basic_flag;
    logic [ByteW-1:0] advanced_flag;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic first;
    logic last;
  } result_t;

endpackage

[rtl/core/cmuxfd_cfg.sv]
// Configuration register file of the frame delineator.
module cmuxfd_cfg import cmuxfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output cfg_t               cfg_o,
  output logic               mode_wr_o
);

  cfg_t cfg_q;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;
  // a mode write of any value drops a partial frame
  assign mode_wr_o   = wr && (cfg_index_i == CFG_FRAME_MODE);
  assign cfg_o       = cfg_q;

  // register writes; indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_mode    <= FRAME_MODE_RST;
      cfg_q.basic_flag    <= BASIC_FLAG_RST;
      cfg_q.advanced_flag <= ADVANCED_FLAG_RST;
    end else if (wr) begin
      case (cfg_index_i)
        CFG_FRAME_MODE:    cfg_q.frame_mode    <= cfg_data_i[0];
        CFG_BASIC_FLAG:    cfg_q.basic_flag    <= cfg_data_i;
        CFG_ADVANCED_FLAG: cfg_q.advanced_flag <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/cmuxfd_parser.sv]
// Per-octet framing state machine: decides pass/drop and first/last marks.
module cmuxfd_parser import cmuxfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             mode_wr_i,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output result_t          res_o
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CTRL  = 3'd2,
    PH_LEN1  = 3'd3,
    PH_LEN2  = 3'd4,
    PH_INFO  = 3'd5,
    PH_CHECK = 3'd6,
    PH_CLOSE = 3'd7
  } phase_e;

  // in advanced mode the "address" phase stands for "inside a frame"
  localparam phase_e PH_INSIDE = PH_ADDR;

  phase_e              phase_q, phase_d;
  logic [LenW-1:0]     left_q, left_d;
  logic [LenLowW-1:0]  low_q, low_d;
  logic [LenW-1:0]     len2;
  logic [LenW-1:0]     left_dec;
  result_t             res;

  assign len2     = {1'b0, byte_i, low_q};
  assign left_dec = left_q - 1'b1;

  // next state and result for the octet being processed
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    low_d   = low_q;
    res     = '0;
    if (cfg_i.frame_mode == MODE_ADVANCED) begin
      if (phase_q == PH_HUNT) begin
        if (byte_i == cfg_i.advanced_flag) begin
          phase_d   = PH_INSIDE;
          res.emit  = 1'b1;
          res.first = 1'b1;
        end
      end else begin
        res.emit = 1'b1;
        if (byte_i == cfg_i.advanced_flag) begin
          phase_d  = PH_HUNT;
          res.last = 1'b1;
        end
      end
    end else begin
      res.emit = 1'b1;
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == cfg_i.basic_flag) begin
            phase_d   = PH_ADDR;
            res.first = 1'b1;
          end else begin
            res.emit = 1'b0;
          end
        end
        PH_ADDR: phase_d = PH_CTRL;
        PH_CTRL: phase_d = PH_LEN1;
        PH_LEN1: begin
          low_d = byte_i[ByteW-1:1];
          if (byte_i[0]) begin
            left_d  = {{(LenW-LenLowW){1'b0}}, byte_i[ByteW-1:1]};
            phase_d = (byte_i[ByteW-1:1] != '0) ? PH_INFO : PH_CHECK;
          end else begin
            phase_d = PH_LEN2;
          end
        end
        PH_LEN2: begin
          left_d  = len2;
          phase_d = (len2 != '0) ? PH_INFO : PH_CHECK;
        end
        PH_INFO: begin
          left_d = left_dec;
          if (left_dec == '0) phase_d = PH_CHECK;
        end
        PH_CHECK: phase_d = PH_CLOSE;
        PH_CLOSE: begin
          // closing position ends the frame whatever the octet holds
          phase_d  = PH_HUNT;
          left_d   = '0;
          low_d    = '0;
          res.last = 1'b1;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  assign res_o = step_i ? res : '0;

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      low_q   <= '0;
    end else if (mode_wr_i) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      low_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      low_q   <= low_d;
    end
  end

  a_mode_wr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_wr_i |=> (phase_q == PH_HUNT) && (left_q == '0) && (low_q == '0))
    else $error("mode write did not clear framing state");

  a_info_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !mode_wr_i && (cfg_i.frame_mode == MODE_BASIC) && (phase_q == PH_INFO)
    |=> left_q == $past(left_dec))
    else $error("information count did not step down");

  a_first_only_from_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.first |-> (phase_q == PH_HUNT) && res_o.emit && !res_o.last)
    else $error("opening mark outside hunt phase");

endmodule

[rtl/core/cmux_frame_delineator.sv]
// Top level of the multiplexer frame delineator: input stage, parser, result register.
//
// Frame delineator for a received octet stream. Takes one octet per clock cycle
// unless the master side stalls it, and forwards only octets that belong to a
// frame (flags included), with tuser marking the opening flag and tlast the octet
// that ends the frame; all other octets are dropped. Throughput is one transaction
// per cycle sustained while m_axis_tready stays high; an accepted octet passes
// through the input register and then the result register before it can be taken
// on the master side. The framing state is updated as an octet leaves the input
// register, so the parser loop sets the rate. s_axis_tready follows m_axis_tready
// combinationally when both stages are full. Configuration writes are always
// accepted and must only be issued while no octet is in flight; a frame_mode write
// discards any partially received frame.
module cmux_frame_delineator import cmuxfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // received octets
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  // framed octets
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [7:0] frame_byte
  output logic               m_axis_tuser,   // [0] frame_first
  output logic               m_axis_tlast,
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  cfg_t             cfg;
  logic             mode_wr;
  result_t          res;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_first_q;
  logic             out_last_q;
  logic             out_free;
  logic             advance;
  logic             in_take;

  cmuxfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .mode_wr_o   (mode_wr)
  );

  // input stage moves on whenever the result register can take a result
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  cmuxfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .mode_wr_i (mode_wr),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .res_o     (res)
  );

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= s_axis_tdata;
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res.emit;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (out_free && advance && res.emit) begin
      out_byte_q  <= in_byte_q;
      out_first_q <= res.first;
      out_last_q  <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_first_q;
  assign m_axis_tlast  = out_last_q;

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && (in_byte_q == $past(in_byte_q)))
    else $error("input stage lost an octet while stalled");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.emit |=> out_valid_q && (out_byte_q == $past(in_byte_q)))
    else $error("passed octet did not reach the result register");

  a_marks_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_first_q && out_last_q))
    else $error("result marked both first and last");

endmodule
